/* hdl/rtpv_pkg.sv */
// ----------------------------------------------------------------------------
// rtpv_pkg
// Shared constants, codes and types of the RTP packet validator.
// ----------------------------------------------------------------------------
package rtpv_pkg;

    localparam int MAX_PACKET_BYTES  = 2048;
    localparam int MAX_PAYLOAD_BYTES = 1024;

    // byte counter saturates at MAX_PACKET_BYTES + 1
    localparam int CNT_W = $clog2(MAX_PACKET_BYTES + 2);
    localparam int FIELD_W = 11;            // payload offset and length fields
    localparam int EXT_W   = 16;            // extension length word
    localparam int EXT_OFS_W = EXT_W + 3;   // offset including a full extension
    localparam int CC_W    = 4;             // CSRC count

    localparam int FIXED_HDR_BYTES = 12;
    localparam int RTP_VERSION     = 2;
    localparam int MAX_PAD_BYTES   = 3;

    // first-byte ranges for demultiplexing
    localparam logic [7:0] DTLS_LO = 8'd20;
    localparam logic [7:0] DTLS_HI = 8'd63;
    localparam logic [7:0] STUN_HI = 8'd3;
    localparam logic [7:0] RTP_LO  = 8'd128;
    localparam logic [7:0] RTP_HI  = 8'd191;

    localparam logic [15:0] SEQ_HIGH_MARK = 16'hc000;
    localparam logic [15:0] SEQ_LOW_MARK  = 16'h4000;

    localparam int OUT_W = 4 + FIELD_W + FIELD_W + 32 + 16 + 32;
    localparam int OUT_DATA_W = ((OUT_W + 7) / 8) * 8;

    typedef enum logic [1:0] {
        CFG_DTLS_ENABLED   = 2'd0,
        CFG_DTLS_SRTP_READY = 2'd1,
        CFG_DISCARD_ENABLE = 2'd2,
        CFG_DISCARD_SSRC   = 2'd3
    } t_cfg_index;

    typedef enum logic [2:0] {
        CLASS_DTLS    = 3'd0,
        CLASS_STUN    = 3'd1,
        CLASS_RTP     = 3'd2,
        CLASS_UNKNOWN = 3'd3
    } t_first_class;

    typedef enum logic [3:0] {
        VERDICT_RTP_OK      = 4'd0,
        VERDICT_RTCP_PASS   = 4'd1,
        VERDICT_DTLS        = 4'd2,
        VERDICT_STUN        = 4'd3,
        VERDICT_HS_WAIT     = 4'd4,
        VERDICT_UNKNOWN     = 4'd5,
        VERDICT_SHORT       = 4'd6,
        VERDICT_VERSION     = 4'd7,
        VERDICT_PADDING     = 4'd8,
        VERDICT_CSRC        = 4'd9,
        VERDICT_EXT         = 4'd10,
        VERDICT_PAYLOAD_BIG = 4'd11,
        VERDICT_DISCARDED   = 4'd12,
        VERDICT_TOO_LONG    = 4'd13
    } t_verdict;

    // packet state as it stands after the current word is captured
    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic [7:0]       flags;
        logic [15:0]      seq;
        logic [31:0]      ssrc;
        logic [EXT_W-1:0] ext_words;
        t_first_class     first_class;
        logic [7:0]       data_byte;
        logic             is_control;
    } t_pkt_view;

    typedef struct packed {
        t_verdict           verdict;
        logic [FIELD_W-1:0] offset;
        logic [FIELD_W-1:0] plen;
        logic [31:0]        ssrc;
        logic [15:0]        seq;
        logic               accept;
    } t_check;

    typedef struct packed {
        logic [31:0]        seq_cycles;
        logic [15:0]        seq;
        logic [31:0]        ssrc;
        logic [FIELD_W-1:0] plen;
        logic [FIELD_W-1:0] offset;
        t_verdict           verdict;
    } t_result;

endpackage

/* hdl/rtpv_capture.sv */
// ----------------------------------------------------------------------------
// rtpv_capture
// Per-packet byte counter and header field capture.
// ----------------------------------------------------------------------------
module rtpv_capture import rtpv_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_step,
    input  logic [7:0] i_byte,
    input  logic      i_last,
    input  logic      i_ctrl,
    output t_pkt_view o_view
);

    logic [CNT_W-1:0] r_count, n_count;
    logic [7:0]       r_flags, n_flags;
    logic [15:0]      r_seq, n_seq;
    logic [31:0]      r_ssrc, n_ssrc;
    logic [EXT_W-1:0] r_ext, n_ext;
    t_first_class     r_class, n_class;
    logic [CNT_W-1:0] ext_base;

    assign ext_base = CNT_W'(FIXED_HDR_BYTES) + CNT_W'({r_flags[CC_W-1:0], 2'b00});

    always_comb begin
        n_count = r_count;
        n_flags = r_flags;
        n_seq   = r_seq;
        n_ssrc  = r_ssrc;
        n_ext   = r_ext;
        n_class = r_class;
        if (r_count <= CNT_W'(MAX_PACKET_BYTES)) begin
            n_count = r_count + CNT_W'(1);
            if (r_count == CNT_W'(0)) begin
                n_flags = i_byte;
                if (i_byte inside {[DTLS_LO:DTLS_HI]}) begin
                    n_class = CLASS_DTLS;
                end else if (i_byte <= STUN_HI) begin
                    n_class = CLASS_STUN;
                end else if (i_byte inside {[RTP_LO:RTP_HI]}) begin
                    n_class = CLASS_RTP;
                end else begin
                    n_class = CLASS_UNKNOWN;
                end
            end
            if (r_count == CNT_W'(2))  n_seq[15:8]   = i_byte;
            if (r_count == CNT_W'(3))  n_seq[7:0]    = i_byte;
            if (r_count == CNT_W'(8))  n_ssrc[31:24] = i_byte;
            if (r_count == CNT_W'(9))  n_ssrc[23:16] = i_byte;
            if (r_count == CNT_W'(10)) n_ssrc[15:8]  = i_byte;
            if (r_count == CNT_W'(11)) n_ssrc[7:0]   = i_byte;
            if (r_count == ext_base + CNT_W'(2)) n_ext[15:8] = i_byte;
            if (r_count == ext_base + CNT_W'(3)) n_ext[7:0]  = i_byte;
        end
    end

    assign o_view = '{count: n_count, flags: n_flags, seq: n_seq, ssrc: n_ssrc,
                      ext_words: n_ext, first_class: n_class, data_byte: i_byte,
                      is_control: i_ctrl};

    // clear the packet state once its last word has gone through
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_last)) begin
            r_count <= '0;
            r_flags <= '0;
            r_seq   <= '0;
            r_ssrc  <= '0;
            r_ext   <= '0;
            r_class <= CLASS_DTLS;
        end else if (i_step) begin
            r_count <= n_count;
            r_flags <= n_flags;
            r_seq   <= n_seq;
            r_ssrc  <= n_ssrc;
            r_ext   <= n_ext;
            r_class <= n_class;
        end
    end

endmodule

/* hdl/rtpv_check.sv */
// ----------------------------------------------------------------------------
// rtpv_check
// Demultiplex and header validation of one closed packet.
// ----------------------------------------------------------------------------
module rtpv_check import rtpv_pkg::*; (
    input  t_pkt_view   i_view,
    input  logic        i_dtls_enabled,
    input  logic        i_dtls_srtp_ready,
    input  logic        i_discard_enable,
    input  logic [31:0] i_discard_ssrc,
    output t_check      o_check
);

    logic [CNT_W-1:0]     len;
    logic [EXT_OFS_W-1:0] ofs_base, ofs_ext, len_x, plen;
    logic                 give_hdr, give_pay;

    always_comb begin
        o_check  = '0;
        give_hdr = 1'b0;
        give_pay = 1'b0;
        len      = i_view.count;
        ofs_base = EXT_OFS_W'(FIXED_HDR_BYTES)
                 + EXT_OFS_W'({i_view.flags[CC_W-1:0], 2'b00});
        ofs_ext  = ofs_base;
        len_x    = '0;
        plen     = '0;
        o_check.verdict = VERDICT_RTP_OK;
        if (i_view.count > CNT_W'(MAX_PACKET_BYTES)) begin
            o_check.verdict = VERDICT_TOO_LONG;
        end else if (i_view.is_control) begin
            o_check.verdict = VERDICT_RTCP_PASS;
        end else if (i_dtls_enabled && i_view.first_class == CLASS_DTLS) begin
            o_check.verdict = VERDICT_DTLS;
        end else if (i_dtls_enabled && i_view.first_class == CLASS_STUN) begin
            o_check.verdict = VERDICT_STUN;
        end else if (i_dtls_enabled && i_view.first_class == CLASS_UNKNOWN) begin
            o_check.verdict = VERDICT_UNKNOWN;
        end else if (i_dtls_enabled && !i_dtls_srtp_ready) begin
            o_check.verdict = VERDICT_HS_WAIT;
        end else if (i_view.count < CNT_W'(FIXED_HDR_BYTES)) begin
            o_check.verdict = VERDICT_SHORT;
        end else begin
            give_hdr = 1'b1;
            if (i_view.flags[7:6] != 2'(RTP_VERSION)) begin
                o_check.verdict = VERDICT_VERSION;
            end else if (i_view.flags[5] && (i_view.data_byte == 8'd0 ||
                                             i_view.data_byte > 8'(MAX_PAD_BYTES))) begin
                o_check.verdict = VERDICT_PADDING;
            end else begin
                // strip the padding count held in the last word
                if (i_view.flags[5]) begin
                    len = i_view.count - CNT_W'(i_view.data_byte);
                end
                len_x = EXT_OFS_W'(len);
                if (i_view.flags[4]) begin
                    ofs_ext = ofs_base + EXT_OFS_W'({i_view.ext_words, 2'b00})
                            + EXT_OFS_W'(4);
                end
                if (ofs_base > len_x) begin
                    o_check.verdict = VERDICT_CSRC;
                end else if (ofs_ext > len_x) begin
                    o_check.verdict = VERDICT_EXT;
                end else begin
                    give_pay = 1'b1;
                    plen = len_x - ofs_ext;
                    if (plen > EXT_OFS_W'(MAX_PAYLOAD_BYTES)) begin
                        o_check.verdict = VERDICT_PAYLOAD_BIG;
                    end else if (i_discard_enable && i_view.ssrc == i_discard_ssrc) begin
                        o_check.verdict = VERDICT_DISCARDED;
                    end else begin
                        o_check.verdict = VERDICT_RTP_OK;
                        o_check.accept  = 1'b1;
                    end
                end
            end
        end
        if (give_pay) begin
            o_check.offset = ofs_ext[FIELD_W-1:0];
            o_check.plen   = plen[FIELD_W-1:0];
        end
        if (give_hdr) begin
            o_check.ssrc = i_view.ssrc;
            o_check.seq  = i_view.seq;
        end
    end

endmodule

/* hdl/rtpv_track.sv */
// ----------------------------------------------------------------------------
// rtpv_track
// Tracked stream state: SSRC, highest sequence number and wrap count.
// ----------------------------------------------------------------------------
module rtpv_track import rtpv_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_commit,
    input  logic [31:0] i_ssrc,
    input  logic [15:0] i_seq,
    output logic [31:0] o_cycles
);

    logic [31:0] r_tracked;
    logic [15:0] r_high, n_high, high_eff;
    logic [31:0] r_wrap, n_wrap, wrap_eff;
    logic        new_src;

    always_comb begin
        new_src  = (r_tracked != i_ssrc);
        high_eff = new_src ? (i_seq - 16'd1) : r_high;
        wrap_eff = new_src ? 32'd0 : r_wrap;
        n_high   = high_eff;
        n_wrap   = wrap_eff;
        if (high_eff < i_seq) begin
            n_high = i_seq;
        end else if (high_eff > SEQ_HIGH_MARK && i_seq < SEQ_LOW_MARK) begin
            n_wrap = wrap_eff + 32'd1;
        end
    end

    // the verdict reports the count after this packet
    assign o_cycles = i_commit ? n_wrap : r_wrap;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tracked <= '0;
            r_high    <= '0;
            r_wrap    <= '0;
        end else if (i_commit) begin
            r_tracked <= i_ssrc;
            r_high    <= n_high;
            r_wrap    <= n_wrap;
        end
    end

endmodule

/* hdl/rtp_packet_demux_validator.sv */
// ----------------------------------------------------------------------------
// rtp_packet_demux_validator
// RTP receive-path header validator with first-byte demultiplexing.
// ----------------------------------------------------------------------------
// Datagram bytes enter one word per cycle on the slave stream, tlast marking
// the final byte and tuser flagging the control (RTCP) port. Every word is
// taken into an input register; from there it updates the packet capture
// (length, first byte, sequence number, SSRC, extension length) and, on the
// last word, the header checks run and one verdict word is written to the
// output register. Throughput is one byte per cycle, except while a last word
// stalls. The output register decouples the two sides, so bytes of the next
// datagram keep flowing while a verdict waits; only a second last word stalls
// until the pending verdict is taken. Configuration registers may be written
// only while no datagram is in flight.
// ----------------------------------------------------------------------------
module rtp_packet_demux_validator import rtpv_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // slave stream
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [7:0]            i_s_tdata,   // [7:0] data_byte
    input  logic                  i_s_tlast,   // last_byte
    input  logic                  i_s_tuser,   // is_control
    // master stream
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    // [3:0] verdict, [14:4] payload_offset, [25:15] payload_length,
    // [57:26] packet_ssrc, [73:58] packet_seq, [105:74] seq_cycles, rest zero
    output logic [OUT_DATA_W-1:0] o_m_tdata,
    // configuration write channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [1:0]            i_cfg_index,
    input  logic [31:0]           i_cfg_data
);

    // configuration registers
    logic        r_dtls_enabled;
    logic        r_dtls_srtp_ready;
    logic        r_discard_enable;
    logic [31:0] r_discard_ssrc;

    // input register
    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_last;
    logic        r_in_ctrl;

    // output register
    logic        r_out_valid;
    t_result     r_out, n_out;

    logic        advance;
    logic        commit;
    t_pkt_view   view;
    t_check      chk;
    logic [31:0] cycles;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dtls_enabled    <= 1'b0;
            r_dtls_srtp_ready <= 1'b0;
            r_discard_enable  <= 1'b0;
            r_discard_ssrc    <= '0;
        end else if (i_cfg_valid) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_DTLS_ENABLED:    r_dtls_enabled    <= i_cfg_data[0];
                CFG_DTLS_SRTP_READY: r_dtls_srtp_ready <= i_cfg_data[0];
                CFG_DISCARD_ENABLE:  r_discard_enable  <= i_cfg_data[0];
                CFG_DISCARD_SSRC:    r_discard_ssrc    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // a plain byte always moves on; a last byte needs room for its verdict
    assign advance    = r_in_valid && (!r_in_last || !r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || advance;
    assign commit     = advance && r_in_last && chk.accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    // hold the payload while the word waits
    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_byte <= i_s_tdata;
            r_in_last <= i_s_tlast;
            r_in_ctrl <= i_s_tuser;
        end
    end

    rtpv_capture u_capture (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (advance),
        .i_byte  (r_in_byte),
        .i_last  (r_in_last),
        .i_ctrl  (r_in_ctrl),
        .o_view  (view)
    );

    rtpv_check u_check (
        .i_view            (view),
        .i_dtls_enabled    (r_dtls_enabled),
        .i_dtls_srtp_ready (r_dtls_srtp_ready),
        .i_discard_enable  (r_discard_enable),
        .i_discard_ssrc    (r_discard_ssrc),
        .o_check           (chk)
    );

    rtpv_track u_track (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_commit (commit),
        .i_ssrc   (view.ssrc),
        .i_seq    (view.seq),
        .o_cycles (cycles)
    );

    always_comb begin
        n_out = '{seq_cycles: cycles, seq: chk.seq, ssrc: chk.ssrc, plen: chk.plen,
                  offset: chk.offset, verdict: chk.verdict};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_last) begin
            r_out <= n_out;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = OUT_DATA_W'(r_out);

endmodule
